FILE: src/kvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants of the key/value table
// Beat layouts for request and response, operation and status codes.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 5;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_PRESENT   = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } kvt_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [31:0]   found_key;
    logic signed [31:0]   found_value;
    logic [ENTRY_W-1:0]   entry_count;
  } kvt_rsp_t;

endpackage

FILE: src/key_value_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table: insertion-ordered key/value table
// Insert, delete with compaction, lookup by key and find by value over a
// small memory, walked one entry at a time by a sequencer.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY (16) key/value pairs in insertion order in
// two memories sharing one read port and one write port. A request beat is
// taken only while the sequencer is idle; it then scans the stored pairs in
// order, each entry examined in a read state and then a compare state,
// because each entry passes through the single registered read port. A
// delete that hits moves every later pair down one slot, each pair read in
// one state and written one slot down in another. A miss on a full table
// scans every entry, then settles the miss and loads the output register.
// Each request gives exactly one response beat; the response sits in an
// output register, and the next request is taken once it has been loaded
// there. miss_value is written through the cfg channel, which is always
// ready, and must only be written while no request is in flight. Store
// contents need no clearing after reset: only entries below the pair count
// are ever read.
// ----------------------------------------------------------------------------
module key_value_table
  import kvt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  // request channel
  input  logic     in_valid,
  output logic     in_ready,
  input  kvt_req_t in_data,
  // response channel
  output logic     out_valid,
  input  logic     out_ready,
  output kvt_rsp_t out_data,
  // miss_value register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;  // read entry idx
  localparam logic [2:0] S_CMP      = 3'd2;  // compare read data
  localparam logic [2:0] S_MISS     = 3'd3;  // scan ran off the end
  localparam logic [2:0] S_SHIFT_RD = 3'd4;  // read entry idx+1
  localparam logic [2:0] S_SHIFT_WR = 3'd5;  // write it to entry idx
  localparam logic [2:0] S_FINISH   = 3'd6;  // hand result to output reg

  logic [2:0]       state;
  kvt_req_t         req;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pair_count;
  logic [31:0]      miss_value;

  // result being built
  logic [1:0]         res_status;
  logic signed [31:0] res_fk;
  logic signed [31:0] res_fv;

  // storage: one read port (registered), one write port
  logic [31:0] key_mem [CAPACITY];
  logic [31:0] val_mem [CAPACITY];
  logic [31:0] key_rd;
  logic [31:0] val_rd;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_key;
  logic [31:0]      wr_val;
  logic             mem_we;

  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_inc2;
  logic             hit;
  logic             out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    idx_inc  = CNT_W'(idx + CNT_W'(1));
    idx_inc2 = CNT_W'(idx + CNT_W'(2));
    // find compares values, everything else compares keys
    hit = (req.operation == OP_FIND) ? (val_rd == req.value) : (key_rd == req.key);
    rd_addr = (state == S_SHIFT_RD) ? idx_inc[IDX_W-1:0] : idx[IDX_W-1:0];
    mem_we  = ((state == S_MISS) && (req.operation == OP_INSERT) &&
               (pair_count < CNT_W'(CAPACITY))) || (state == S_SHIFT_WR);
    // insert appends at the count; compaction writes the slot below
    if (state == S_MISS) begin
      wr_addr = pair_count[IDX_W-1:0];
      wr_key  = req.key;
      wr_val  = req.value;
    end else begin
      wr_addr = idx[IDX_W-1:0];
      wr_key  = key_rd;
      wr_val  = val_rd;
    end
  end

  always_ff @(posedge clk) begin
    key_rd <= key_mem[rd_addr];
    val_rd <= val_mem[rd_addr];
    if (mem_we) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pair_count <= '0;
      miss_value <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        miss_value <= cfg_data;
      end
      // output register: loaded from S_FINISH, emptied when taken
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req        <= in_data;
            idx        <= '0;
            res_status <= ST_NOT_FOUND;
            res_fk     <= miss_value;
            res_fv     <= miss_value;
            state      <= (pair_count == '0) ? S_MISS : S_SCAN;
          end
        end

        S_SCAN: begin
          state <= S_CMP;
        end

        S_CMP: begin
          if (hit) begin
            unique case (req.operation)
              OP_INSERT: begin
                res_status <= ST_PRESENT;
                state      <= S_FINISH;
              end
              OP_DELETE: begin
                res_status <= ST_DONE;
                if (idx_inc < pair_count) begin
                  state <= S_SHIFT_RD;
                end else begin
                  pair_count <= CNT_W'(pair_count - CNT_W'(1));
                  state      <= S_FINISH;
                end
              end
              OP_LOOKUP: begin
                res_status <= ST_DONE;
                res_fv     <= val_rd;
                state      <= S_FINISH;
              end
              default: begin
                res_status <= ST_DONE;
                res_fk     <= key_rd;
                state      <= S_FINISH;
              end
            endcase
          end else if (idx_inc == pair_count) begin
            state <= S_MISS;
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN;
          end
        end

        S_MISS: begin
          // only insert acts on a miss; others keep not-found
          if (req.operation == OP_INSERT) begin
            if (pair_count < CNT_W'(CAPACITY)) begin
              pair_count <= CNT_W'(pair_count + CNT_W'(1));
              res_status <= ST_DONE;
            end else begin
              res_status <= ST_FULL;
            end
          end
          state <= S_FINISH;
        end

        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end

        S_SHIFT_WR: begin
          if (idx_inc2 < pair_count) begin
            idx   <= idx_inc;
            state <= S_SHIFT_RD;
          end else begin
            pair_count <= CNT_W'(pair_count - CNT_W'(1));
            state      <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_data  <= '{status:      res_status,
                           found_key:   res_fk,
                           found_value: res_fv,
                           entry_count: ENTRY_W'(pair_count)};
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count <= CNT_W'(CAPACITY))
    else $error("pair count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  a_count_at_end: assert property (@(posedge clk) disable iff (rst)
    (pair_count != $past(pair_count)) |-> (state == S_FINISH))
    else $error("pair count changed mid-request");

  a_append_in_range: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == S_MISS)) |-> (pair_count < CNT_W'(CAPACITY)))
    else $error("append into a full table");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_WR) |-> (idx_inc < pair_count))
    else $error("compaction read past the count");

endmodule
